>>> rtl/core/udf_pkg.sv
package udf_pkg;

	localparam int VALUE_BITS = 64;
	localparam int MAX_FIELD  = 64;
	localparam int BCD_DIGITS = 20;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int FIELD_W    = 7;
	localparam int NDIG_W     = $clog2(BCD_DIGITS + 1);
	localparam int DIDX_W     = $clog2(BCD_DIGITS);
	localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_LEAD,
		ST_SIZE,
		ST_PLACE,
		ST_EMIT
	} udf_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} udf_bcd_stat_t;

endpackage

>>> rtl/core/udf_if.sv
interface udf_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [6:0]  width;
	logic [7:0]  digits_min;
	logic        left_justify;
	logic        zero_pad;

	modport source (output valid, value, width, digits_min, left_justify, zero_pad,
		input ready);
	modport sink (input valid, value, width, digits_min, left_justify, zero_pad,
		output ready);
endinterface

interface udf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       last;
	logic [6:0] total_chars;

	modport source (output valid, char_out, last, total_chars, input ready);
	modport sink (input valid, char_out, last, total_chars, output ready);
endinterface

>>> rtl/core/udf_bcd.sv
module udf_bcd import udf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] value,
	output udf_bcd_stat_t         stat,
	output logic [BCD_W-1:0]      digits
);

	logic [VALUE_BITS-1:0] shift_q;
	logic [BCD_W-1:0]      digits_q;
	logic [BCD_W-1:0]      adj;
	logic [BIT_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic                  last_bit;

	assign last_bit = (cnt_q == BIT_CNT_W'(VALUE_BITS - 1));

	// double dabble: add 3 to every digit of 5 or more, then shift one bit in
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (digits_q[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = digits_q[4*i +: 4] + 4'd3;
			else
				adj[4*i +: 4] = digits_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_bit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q  <= value;
			digits_q <= '0;
		end else if (busy_q) begin
			shift_q  <= shift_q << 1;
			digits_q <= {adj[BCD_W-2:0], shift_q[VALUE_BITS-1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign digits    = digits_q;

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("conversion done while still shifting");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && cnt_q == '0)
		else $error("conversion did not start cleanly");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && last_bit && !start |=> done_q && !busy_q)
		else $error("conversion did not finish after last bit");
`endif

endmodule

>>> rtl/core/unsigned_decimal_formatter.sv
// Flow: a request is taken in ST_IDLE, then the value is converted to BCD bit-serially
// over its VALUE_BITS (64 here) bits, the done flag is raised and the sizing states
// ST_LEAD, ST_SIZE and ST_PLACE run before the first character is presented.
// Rate: the double-dabble loop shifts one bit per cycle and the output one character per
// cycle while chars.ready holds; a new request is taken only after the last character.
// The last character may wait in the output register while the next request is taken.
// Reset: arst_n clears the controller and output valid asynchronously; data regs are not reset.
module unsigned_decimal_formatter import udf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	udf_in_if.sink    item,
	udf_out_if.source chars
);

	udf_state_t state_q, state_d;

	logic [FIELD_W-1:0] width_q, prec_q, zeros_q, core_q;
	logic [FIELD_W-1:0] b1_q, b2_q, b3_q, total_q, pos_q;
	logic [NDIG_W-1:0]  nd_q, nd_d;
	logic               has_prec_q, left_q, padz_q;

	logic [7:0]         char_q;
	logic               last_q;
	logic [6:0]         total_out_q;
	logic               out_valid_q;

	logic               accept, bcd_start, emit_load, last_pos;
	udf_bcd_stat_t      bcd_stat;
	logic [BCD_W-1:0]   bcd_digits;
	logic [3:0]         dig_arr [BCD_DIGITS];

	logic               has_prec_in;
	logic [6:0]         prec_raw;
	logic [FIELD_W-1:0] spaces_d, total_d, b1_d;
	logic [FIELD_W-1:0] didx_full;
	logic [DIDX_W-1:0]  didx;
	logic [3:0]         digit;
	logic [7:0]         char_d;

	udf_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.value  (item.value[VALUE_BITS-1:0]),
		.stat   (bcd_stat),
		.digits (bcd_digits)
	);

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++)
			dig_arr[i] = bcd_digits[4*i +: 4];
	end

	assign accept      = item.valid && item.ready;
	assign has_prec_in = !item.digits_min[7];
	assign prec_raw    = item.digits_min[6:0];

	// count of significant digits; a zero still prints one digit unless precision is zero
	always_comb begin
		nd_d = '0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (dig_arr[i] != 4'd0)
				nd_d = NDIG_W'(i + 1);
		end
		if (nd_d == '0 && !(has_prec_q && prec_q == '0))
			nd_d = NDIG_W'(1);
	end

	always_comb begin
		spaces_d = (width_q > core_q) ? width_q - core_q : '0;
		total_d  = (width_q > core_q) ? width_q : core_q;
		b1_d     = left_q ? '0 : spaces_d;
	end

	// layout: [0,b1) pad, [b1,b2) precision zeros, [b2,b3) digits, then trailing spaces
	assign last_pos  = (pos_q == total_q - 1'b1);
	assign didx_full = b3_q - 1'b1 - pos_q;
	assign didx      = didx_full[DIDX_W-1:0];
	assign digit     = dig_arr[didx];

	always_comb begin
		priority if (pos_q < b1_q)
			char_d = padz_q ? CHAR_ZERO : CHAR_SPACE;
		else if (pos_q < b2_q)
			char_d = CHAR_ZERO;
		else if (pos_q < b3_q)
			char_d = CHAR_ZERO | {4'b0000, digit};
		else
			char_d = CHAR_SPACE;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (item.valid) state_d = ST_CONV;
			ST_CONV:  if (bcd_stat.done) state_d = ST_LEAD;
			ST_LEAD:  state_d = ST_SIZE;
			ST_SIZE:  state_d = ST_PLACE;
			ST_PLACE: state_d = (total_d == '0) ? ST_IDLE : ST_EMIT;
			ST_EMIT:  if (emit_load && last_pos) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready = (state_q == ST_IDLE);
		bcd_start  = item.valid && (state_q == ST_IDLE);
		emit_load  = (state_q == ST_EMIT) && (!out_valid_q || chars.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_load)
				out_valid_q <= 1'b1;
			else if (chars.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			width_q    <= (item.width > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD) : item.width;
			has_prec_q <= has_prec_in;
			if (!has_prec_in)
				prec_q <= '0;
			else if (prec_raw > FIELD_W'(MAX_FIELD))
				prec_q <= FIELD_W'(MAX_FIELD);
			else
				prec_q <= prec_raw;
			left_q <= item.left_justify;
			padz_q <= !item.left_justify && item.zero_pad && !has_prec_in;
		end
		if (state_q == ST_LEAD)
			nd_q <= nd_d;
		if (state_q == ST_SIZE) begin
			zeros_q <= (prec_q > FIELD_W'(nd_q)) ? prec_q - FIELD_W'(nd_q) : '0;
			core_q  <= (prec_q > FIELD_W'(nd_q)) ? prec_q : FIELD_W'(nd_q);
		end
		if (state_q == ST_PLACE) begin
			b1_q    <= b1_d;
			b2_q    <= b1_d + zeros_q;
			b3_q    <= b1_d + core_q;
			total_q <= total_d;
			pos_q   <= '0;
		end else if (emit_load) begin
			pos_q <= pos_q + 1'b1;
		end
		if (emit_load) begin
			char_q      <= char_d;
			last_q      <= last_pos;
			total_out_q <= total_q;
		end
	end

	assign chars.valid       = out_valid_q;
	assign chars.char_out    = char_q;
	assign chars.last        = last_q;
	assign chars.total_chars = total_out_q;

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> pos_q < total_q)
		else $error("character position beyond total");
	a_done_conv: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_stat.done |-> state_q == ST_CONV)
		else $error("conversion finished outside conversion state");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load && last_pos |=> state_q == ST_IDLE && out_valid_q && last_q)
		else $error("final character not followed by idle");
`endif

endmodule
